[hdl/vips_pkg.sv]
// ----------------------------------------------------------------------------
// vips_pkg
// Shared types, register indexes and constants of the vertex ink projection
// shader.
// ----------------------------------------------------------------------------
package vips_pkg;

  // Configuration register indexes
  localparam logic [2:0] CfgEyeZ   = 3'd0;
  localparam logic [2:0] CfgNear   = 3'd1;
  localparam logic [2:0] CfgFar    = 3'd2;
  localparam logic [2:0] CfgRefX   = 3'd3;
  localparam logic [2:0] CfgRefY   = 3'd4;
  localparam logic [2:0] CfgRefZ   = 3'd5;
  localparam logic [2:0] CfgScale  = 3'd6;

  // Gray level arithmetic: (GrayBase*one - GrayGain*d + GrayHalf*one) / (100*one)
  localparam int GrayBase  = 20400;
  localparam int GrayGain  = 765;
  localparam int GrayHalf  = 50;
  localparam int DotLim    = 64;
  // Divide by 100 as multiply by ceil(2^22/100), exact below GraySatT
  localparam logic [15:0] GrayRecip = 16'd41944;
  localparam int GrayShift = 22;
  localparam logic [16:0] GraySatT = 17'd25500;

  // Normalized vector component, root and divider widths
  localparam int CompW = 31;
  localparam int SqW   = 64;
  localparam int DivQW = 10;
  localparam int NumW  = 42;

  // Control fields that travel with a vertex
  typedef struct packed {
    logic       skip;
    logic       far;
    logic [7:0] lvl;
    logic       last;
  } ctl_t;

  // Saturate a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v[63:31] != {33{v[31]}}) begin
      r = v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/vertex_ink_projection_shader.sv]
// ----------------------------------------------------------------------------
// vertex_ink_projection_shader
// Per-vertex point decision: eye vector, reflection, sphere-map projection to
// screen coordinates and a gray shade for far points.
// ----------------------------------------------------------------------------
// Throughput: one vertex per cycle while the output is not stalled; the
//   31-step square root and the 10-step divider are unrolled into pipeline
//   stages, one result bit per stage.
// An output stall freezes every stage at once; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults.
module vertex_ink_projection_shader #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] norm_x_i,
  input  logic signed [31:0] norm_y_i,
  input  logic signed [31:0] norm_z_i,
  input  logic               last_vertex_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               drawn_o,
  output logic               style_o,
  output logic [7:0]         gray_level_o,
  output logic [9:0]         screen_x_o,
  output logic [9:0]         screen_y_o,
  output logic               last_point_o
);

  localparam logic signed [63:0] One = 64'sd1 <<< FRAC_BITS;
  localparam int CW = vips_pkg::CompW;
  localparam int SqSteps = CW;
  localparam int DvSteps = vips_pkg::DivQW;
  localparam int NW = vips_pkg::NumW;

  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] eye_z_q, near_q, far_q, ref_x_q, ref_y_q, ref_z_q;
  logic [9:0]         scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_z_q <= 32'sd1966080;
      near_q  <= 32'sd327680;
      far_q   <= 32'sd1310720;
      ref_x_q <= 32'sd0;
      ref_y_q <= -32'sd327680;
      ref_z_q <= -32'sd1966080;
      scale_q <= 10'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        vips_pkg::CfgEyeZ:  eye_z_q <= cfg_wdata_i;
        vips_pkg::CfgNear:  near_q  <= cfg_wdata_i;
        vips_pkg::CfgFar:   far_q   <= cfg_wdata_i;
        vips_pkg::CfgRefX:  ref_x_q <= cfg_wdata_i;
        vips_pkg::CfgRefY:  ref_y_q <= cfg_wdata_i;
        vips_pkg::CfgRefZ:  ref_z_q <= cfg_wdata_i;
        vips_pkg::CfgScale: scale_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: the whole pipe holds while a result word is stalled
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  logic [9:0] fv_q;
  logic [SqSteps:0] sv_q;
  logic a_v_q;
  logic [DvSteps:0] dv_v_q;

  // --------------------------------------------------------------------------
  // S1: eye vector and offset from the reference point, saturated
  // --------------------------------------------------------------------------
  logic signed [31:0] s1_ex_q, s1_ey_q, s1_ez_q, s1_dx_q, s1_dy_q, s1_dz_q;
  logic signed [31:0] s1_nx_q, s1_ny_q, s1_nz_q;
  logic               s1_last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ex_q   <= pos_x_i;
      s1_ey_q   <= pos_y_i;
      s1_ez_q   <= vips_pkg::sat33(33'(pos_z_i) - 33'(eye_z_q));
      s1_dx_q   <= vips_pkg::sat33(33'(pos_x_i) - 33'(ref_x_q));
      s1_dy_q   <= vips_pkg::sat33(33'(pos_y_i) - 33'(ref_y_q));
      s1_dz_q   <= vips_pkg::sat33(33'(pos_z_i) - 33'(ref_z_q));
      s1_nx_q   <= norm_x_i;
      s1_ny_q   <= norm_y_i;
      s1_nz_q   <= norm_z_i;
      s1_last_q <= last_vertex_i;
    end
  end

  // --------------------------------------------------------------------------
  // S2: products for alfa and the shading dot product
  // --------------------------------------------------------------------------
  logic signed [63:0] s2_ax_q, s2_ay_q, s2_az_q, s2_dx_q, s2_dy_q, s2_dz_q;
  logic signed [31:0] s2_ex_q, s2_ey_q, s2_ez_q;
  logic               s2_last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ax_q   <= qmul(s1_nx_q, s1_ex_q);
      s2_ay_q   <= qmul(s1_ny_q, s1_ey_q);
      s2_az_q   <= qmul(s1_nz_q, s1_ez_q);
      s2_dx_q   <= qmul(s1_dx_q, s1_nx_q);
      s2_dy_q   <= qmul(s1_dy_q, s1_ny_q);
      s2_dz_q   <= qmul(s1_dz_q, s1_nz_q);
      s2_ex_q   <= s1_ex_q;
      s2_ey_q   <= s1_ey_q;
      s2_ez_q   <= s1_ez_q;
      s2_last_q <= s1_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // S3: sum alfa, sum and clamp the shading dot product
  // --------------------------------------------------------------------------
  localparam logic signed [63:0] DLim = 64'(vips_pkg::DotLim) <<< FRAC_BITS;
  logic signed [63:0] s3_alfa_q, s3_d_q, s3_dsum;
  logic signed [31:0] s3_ex_q, s3_ey_q, s3_ez_q;
  logic               s3_last_q;

  assign s3_dsum = s2_dx_q + s2_dy_q + s2_dz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_alfa_q <= s2_ax_q + s2_ay_q + s2_az_q;
      if (s3_dsum > DLim) begin
        s3_d_q <= DLim;
      end else if (s3_dsum < -DLim) begin
        s3_d_q <= -DLim;
      end else begin
        s3_d_q <= s3_dsum;
      end
      s3_ex_q   <= s2_ex_q;
      s3_ey_q   <= s2_ey_q;
      s3_ez_q   <= s2_ez_q;
      s3_last_q <= s2_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // S4: classify, reflection factor, gray numerator
  // --------------------------------------------------------------------------
  localparam logic signed [63:0] GBase = 64'(vips_pkg::GrayBase) <<< FRAC_BITS;
  localparam logic signed [63:0] GHalf = 64'(vips_pkg::GrayHalf) <<< FRAC_BITS;
  logic signed [63:0] s4_gnum, s4_gsum;
  logic signed [31:0] s4_s_q, s4_ex_q, s4_ey_q, s4_ez_q;
  logic [16:0]        s4_t_q;
  logic               s4_skip_q, s4_far_q, s4_last_q;

  always_comb begin
    s4_gnum = GBase - 64'(vips_pkg::GrayGain) * s3_d_q;
    if (s4_gnum < 0) begin
      s4_gnum = '0;
    end
    s4_gsum = (s4_gnum + GHalf) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_skip_q <= s3_alfa_q < 64'(near_q);
      s4_far_q  <= s3_alfa_q > 64'(far_q);
      s4_s_q    <= vips_pkg::sat64((s3_alfa_q <<< 1) - One);
      s4_t_q    <= s4_gsum[16:0];
      s4_ex_q   <= s3_ex_q;
      s4_ey_q   <= s3_ey_q;
      s4_ez_q   <= s3_ez_q;
      s4_last_q <= s3_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // S5: reflected vector, gray level
  // --------------------------------------------------------------------------
  logic signed [63:0] s5_rx_q, s5_ry_q, s5_rz_q;
  logic [32:0]        s5_gprod;
  vips_pkg::ctl_t     s5_ctl_q;

  assign s5_gprod = 33'(s4_t_q) * 33'(vips_pkg::GrayRecip);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_rx_q       <= qmul(s4_s_q, s4_ex_q);
      s5_ry_q       <= qmul(s4_s_q, s4_ey_q);
      s5_rz_q       <= qmul(s4_s_q, s4_ez_q);
      s5_ctl_q.skip <= s4_skip_q;
      s5_ctl_q.far  <= s4_far_q;
      s5_ctl_q.last <= s4_last_q;
      s5_ctl_q.lvl  <= (s4_t_q >= vips_pkg::GraySatT) ? 8'd255 :
                       s5_gprod[vips_pkg::GrayShift +: 8];
    end
  end

  // --------------------------------------------------------------------------
  // S6: lift z by one
  // --------------------------------------------------------------------------
  logic signed [63:0] s6_rx_q, s6_ry_q, s6_rz_q;
  vips_pkg::ctl_t     s6_ctl_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_rx_q  <= s5_rx_q;
      s6_ry_q  <= s5_ry_q;
      s6_rz_q  <= s5_rz_q + One;
      s6_ctl_q <= s5_ctl_q;
    end
  end

  // --------------------------------------------------------------------------
  // S7: merge magnitudes; the top set bit matches that of the largest one
  // --------------------------------------------------------------------------
  logic signed [63:0] s7_rx_q, s7_ry_q, s7_rz_q;
  logic [63:0]        s7_mor_q;
  vips_pkg::ctl_t     s7_ctl_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_mor_q <= mag64(s6_rx_q) | mag64(s6_ry_q) | mag64(s6_rz_q);
      s7_rx_q  <= s6_rx_q;
      s7_ry_q  <= s6_ry_q;
      s7_rz_q  <= s6_rz_q;
      s7_ctl_q <= s6_ctl_q;
    end
  end

  // --------------------------------------------------------------------------
  // S8: normalizing shift amount
  // --------------------------------------------------------------------------
  logic [5:0]         s8_msb;
  logic [5:0]         s8_k_q;
  logic signed [63:0] s8_rx_q, s8_ry_q, s8_rz_q;
  vips_pkg::ctl_t     s8_ctl_q;

  always_comb begin
    s8_msb = '0;
    for (int b = 0; b < 64; b++) begin
      if (s7_mor_q[b]) begin
        s8_msb = 6'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_k_q   <= (s8_msb >= 6'd30) ? s8_msb - 6'd29 : 6'd0;
      s8_rx_q  <= s7_rx_q;
      s8_ry_q  <= s7_ry_q;
      s8_rz_q  <= s7_rz_q;
      s8_ctl_q <= s7_ctl_q;
    end
  end

  // --------------------------------------------------------------------------
  // S9: shift into 31-bit components
  // --------------------------------------------------------------------------
  logic signed [63:0] s9_sx, s9_sy, s9_sz;
  logic signed [CW-1:0] s9_cx_q, s9_cy_q, s9_cz_q;
  vips_pkg::ctl_t     s9_ctl_q;

  assign s9_sx = s8_rx_q >>> s8_k_q;
  assign s9_sy = s8_ry_q >>> s8_k_q;
  assign s9_sz = s8_rz_q >>> s8_k_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_cx_q  <= s9_sx[CW-1:0];
      s9_cy_q  <= s9_sy[CW-1:0];
      s9_cz_q  <= s9_sz[CW-1:0];
      s9_ctl_q <= s8_ctl_q;
    end
  end

  // --------------------------------------------------------------------------
  // S10: squares
  // --------------------------------------------------------------------------
  logic signed [2*CW-1:0] s10_px, s10_py, s10_pz;
  logic [2*CW-1:0]        s10_qx_q, s10_qy_q, s10_qz_q;
  logic signed [CW-1:0]   s10_cx_q, s10_cy_q;
  vips_pkg::ctl_t         s10_ctl_q;

  assign s10_px = (2*CW)'(s9_cx_q) * (2*CW)'(s9_cx_q);
  assign s10_py = (2*CW)'(s9_cy_q) * (2*CW)'(s9_cy_q);
  assign s10_pz = (2*CW)'(s9_cz_q) * (2*CW)'(s9_cz_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_qx_q  <= s10_px;
      s10_qy_q  <= s10_py;
      s10_qz_q  <= s10_pz;
      s10_cx_q  <= s9_cx_q;
      s10_cy_q  <= s9_cy_q;
      s10_ctl_q <= s9_ctl_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: stage 0 sums, stages 1..31 settle one root bit each
  // --------------------------------------------------------------------------
  logic [vips_pkg::SqW-1:0] sq_rem_q  [SqSteps+1];
  logic [CW-1:0]            sq_root_q [SqSteps+1];
  logic signed [CW-1:0]     sq_cx_q   [SqSteps+1];
  logic signed [CW-1:0]     sq_cy_q   [SqSteps+1];
  vips_pkg::ctl_t           sq_ctl_q  [SqSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q[0]  <= 64'(s10_qx_q) + 64'(s10_qy_q) + 64'(s10_qz_q);
      sq_root_q[0] <= '0;
      sq_cx_q[0]   <= s10_cx_q;
      sq_cy_q[0]   <= s10_cy_q;
      sq_ctl_q[0]  <= s10_ctl_q;
    end
  end

  for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
    localparam int Bit = SqSteps - 1 - j;
    logic [vips_pkg::SqW-1:0] trial;
    assign trial = (64'(sq_root_q[j]) << (Bit + 1)) + (64'd1 << (2 * Bit));

    // Take the bit when the remainder covers the trial step
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (sq_rem_q[j] >= trial) begin
          sq_rem_q[j+1]  <= sq_rem_q[j] - trial;
          sq_root_q[j+1] <= sq_root_q[j] | (CW'(1) << Bit);
        end else begin
          sq_rem_q[j+1]  <= sq_rem_q[j];
          sq_root_q[j+1] <= sq_root_q[j];
        end
        sq_cx_q[j+1]  <= sq_cx_q[j];
        sq_cy_q[j+1]  <= sq_cy_q[j];
        sq_ctl_q[j+1] <= sq_ctl_q[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // A: shifted components m + c, divisor 2m
  // --------------------------------------------------------------------------
  logic signed [CW+1:0] a_sx, a_sy;
  logic [31:0]          a_nx_q, a_ny_q, a_den_q;
  logic                 a_mz_q;
  vips_pkg::ctl_t       a_ctl_q;

  assign a_sx = (CW+2)'(sq_root_q[SqSteps]) + (CW+2)'(sq_cx_q[SqSteps]);
  assign a_sy = (CW+2)'(sq_root_q[SqSteps]) + (CW+2)'(sq_cy_q[SqSteps]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_nx_q  <= a_sx[31:0];
      a_ny_q  <= a_sy[31:0];
      a_den_q <= {sq_root_q[SqSteps], 1'b0};
      a_mz_q  <= (sq_root_q[SqSteps] == '0);
      a_ctl_q <= sq_ctl_q[SqSteps];
    end
  end

  // --------------------------------------------------------------------------
  // Divider: stage 0 scales, stages 1..10 settle one quotient bit each
  // --------------------------------------------------------------------------
  logic [NW-1:0]       dv_rx_q  [DvSteps+1];
  logic [NW-1:0]       dv_ry_q  [DvSteps+1];
  logic [DvSteps-1:0]  dv_qx_q  [DvSteps+1];
  logic [DvSteps-1:0]  dv_qy_q  [DvSteps+1];
  logic [31:0]         dv_den_q [DvSteps+1];
  logic                dv_mz_q  [DvSteps+1];
  vips_pkg::ctl_t      dv_ctl_q [DvSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rx_q[0]  <= NW'(a_nx_q) * NW'(scale_q);
      dv_ry_q[0]  <= NW'(a_ny_q) * NW'(scale_q);
      dv_qx_q[0]  <= '0;
      dv_qy_q[0]  <= '0;
      dv_den_q[0] <= a_den_q;
      dv_mz_q[0]  <= a_mz_q;
      dv_ctl_q[0] <= a_ctl_q;
    end
  end

  for (genvar j = 0; j < DvSteps; j++) begin : g_div
    localparam int Bit = DvSteps - 1 - j;
    logic [NW-1:0] step;
    assign step = NW'(dv_den_q[j]) << Bit;

    // Subtract the shifted divisor where it fits, per lane
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (dv_rx_q[j] >= step) begin
          dv_rx_q[j+1] <= dv_rx_q[j] - step;
          dv_qx_q[j+1] <= dv_qx_q[j] | (DvSteps'(1) << Bit);
        end else begin
          dv_rx_q[j+1] <= dv_rx_q[j];
          dv_qx_q[j+1] <= dv_qx_q[j];
        end
        if (dv_ry_q[j] >= step) begin
          dv_ry_q[j+1] <= dv_ry_q[j] - step;
          dv_qy_q[j+1] <= dv_qy_q[j] | (DvSteps'(1) << Bit);
        end else begin
          dv_ry_q[j+1] <= dv_ry_q[j];
          dv_qy_q[j+1] <= dv_qy_q[j];
        end
        dv_den_q[j+1] <= dv_den_q[j];
        dv_mz_q[j+1]  <= dv_mz_q[j];
        dv_ctl_q[j+1] <= dv_ctl_q[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output word
  // --------------------------------------------------------------------------
  vips_pkg::ctl_t o_ctl;
  logic           drawn_q, style_q, last_q;
  logic [7:0]     gray_q;
  logic [9:0]     sx_q, sy_q;

  assign o_ctl = dv_ctl_q[DvSteps];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drawn_q <= !o_ctl.skip;
      last_q  <= o_ctl.last;
      if (o_ctl.skip) begin
        style_q <= 1'b0;
        gray_q  <= '0;
        sx_q    <= '0;
        sy_q    <= '0;
      end else begin
        style_q <= o_ctl.far;
        gray_q  <= o_ctl.far ? o_ctl.lvl : 8'd0;
        sx_q    <= dv_mz_q[DvSteps] ? (scale_q >> 1) : dv_qx_q[DvSteps];
        sy_q    <= dv_mz_q[DvSteps] ? (scale_q >> 1) : dv_qy_q[DvSteps];
      end
    end
  end

  // Advance valid bits with their words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q        <= '0;
      sv_q        <= '0;
      a_v_q       <= 1'b0;
      dv_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      fv_q        <= {fv_q[8:0], in_valid_i};
      sv_q        <= {sv_q[SqSteps-1:0], fv_q[9]};
      a_v_q       <= sv_q[SqSteps];
      dv_v_q      <= {dv_v_q[DvSteps-1:0], a_v_q};
      out_valid_q <= dv_v_q[DvSteps];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drawn_o      = drawn_q;
  assign style_o      = style_q;
  assign gray_level_o = gray_q;
  assign screen_x_o   = sx_q;
  assign screen_y_o   = sy_q;
  assign last_point_o = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drawn_o |-> !style_o && gray_level_o == 8'd0 &&
      screen_x_o == 10'd0 && screen_y_o == 10'd0)
    else $error("skipped vertex carries nonzero fields");

  a_black_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drawn_o && !style_o |-> gray_level_o == 8'd0)
    else $error("black point carries a gray level");

  a_screen_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drawn_o |-> screen_x_o <= scale_q && screen_y_o <= scale_q)
    else $error("screen coordinate beyond screen scale");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> fv_q[0])
    else $error("accepted vertex lost at pipeline entry");

endmodule

[tb/tb_vertex_ink_projection_shader.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_ink_projection_shader
// Drives vertices through the shader with random idling on both channels,
// predicts every result word in fixed point and compares field by field.
// A directed table covers extremes and the skip, black, gray and centre
// cases; random vertices follow, in phases with different register settings.
// ----------------------------------------------------------------------------
module tb_vertex_ink_projection_shader;

  localparam int Latency   = 55;
  localparam int CycleLim  = 400000;
  localparam int NumRandom = 1620;

  // Register index that no register answers to
  localparam logic [2:0] CfgUnused = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i, norm_x_i, norm_y_i, norm_z_i;
  logic        last_vertex_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        drawn_o, style_o, last_point_o;
  logic [7:0]  gray_level_o;
  logic [9:0]  screen_x_o, screen_y_o;

  vertex_ink_projection_shader dut (.*);

  typedef struct {
    logic signed [31:0] px, py, pz, nx, ny, nz;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic       drawn;
    logic       style;
    logic [7:0] gray;
    logic [9:0] sx;
    logic [9:0] sy;
    logic       last;
  } point_t;

  // Shadow registers
  longint eye_z, near_th, far_th, rx_ref, ry_ref, rz_ref;
  longint scale;

  point_t expected_points[$];
  int     mismatches;
  int     cycles;
  bit     idle_off;
  bit     hold_off;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Arithmetic shift is floor division by a power of two
  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint babs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [9:0] to_pixel(longint c, longint m);
    longint num, r;
    if (m == 0) return 10'(scale >> 1);
    num = scale * (m + c);
    if (num < 0) num = 0;
    r = num / (2 * m);
    if (r > 1023) r = 1023;
    return 10'(r);
  endfunction

  // Shade and project one vertex
  function automatic point_t shade_vertex(vertex_t v);
    point_t p;
    longint one, ez, alfa, s, rx, ry, rz, big, m, d, num, lvl;
    longint unsigned sq;
    int k;
    one = 64'sd1 << 16;
    p = '{drawn: 0, style: 0, gray: 0, sx: 0, sy: 0, last: v.last};
    ez = clip32(longint'(v.pz) - eye_z);
    alfa = fmul(v.nx, v.px) + fmul(v.ny, v.py) + fmul(v.nz, ez);
    if (alfa < near_th) return p;
    s = clip32(2 * alfa - one);
    rx = fmul(s, v.px);
    ry = fmul(s, v.py);
    rz = fmul(s, ez) + one;
    big = babs(rx);
    if (babs(ry) > big) big = babs(ry);
    if (babs(rz) > big) big = babs(rz);
    k = 0;
    while (k < 62 && (big >>> k) >= (64'sd1 << 30)) k++;
    rx = rx >>> k;
    ry = ry >>> k;
    rz = rz >>> k;
    sq = longint'(rx * rx) + longint'(ry * ry) + longint'(rz * rz);
    m = int_root(sq);
    p.drawn = 1;
    p.sx = to_pixel(rx, m);
    p.sy = to_pixel(ry, m);
    if (alfa > far_th) begin
      d = fmul(clip32(longint'(v.px) - rx_ref), v.nx)
        + fmul(clip32(longint'(v.py) - ry_ref), v.ny)
        + fmul(clip32(longint'(v.pz) - rz_ref), v.nz);
      if (d > (64'sd64 << 16)) d = 64'sd64 << 16;
      if (d < -(64'sd64 << 16)) d = -(64'sd64 << 16);
      num = 20400 * one - 765 * d;
      if (num < 0) num = 0;
      lvl = (num + 50 * one) / (100 * one);
      if (lvl > 255) lvl = 255;
      p.style = 1;
      p.gray = 8'(lvl);
    end
    return p;
  endfunction

  // Clock
  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLim) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall, long hold-off on request
  initial begin
    out_stall_i = 1;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_stall_i <= 1;
      else if (idle_off) out_stall_i <= 0;
      else out_stall_i <= ($urandom_range(99) < 32);
    end
  end

  // Check each accepted result word
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        e = expected_points.pop_front();
        if (drawn_o !== e.drawn || style_o !== e.style || gray_level_o !== e.gray ||
            screen_x_o !== e.sx || screen_y_o !== e.sy || last_point_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp d%0d s%0d g%0d x%0d y%0d l%0d",
                      " got d%0d s%0d g%0d x%0d y%0d l%0d"},
                     e.drawn, e.style, e.gray, e.sx, e.sy, e.last, drawn_o, style_o,
                     gray_level_o, screen_x_o, screen_y_o, last_point_o);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    @(negedge clk_i);
    cfg_we_i    <= 1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= 32'(val);
    case (idx)
      vips_pkg::CfgEyeZ:  eye_z   = longint'(signed'(32'(val)));
      vips_pkg::CfgNear:  near_th = longint'(signed'(32'(val)));
      vips_pkg::CfgFar:   far_th  = longint'(signed'(32'(val)));
      vips_pkg::CfgRefX:  rx_ref  = longint'(signed'(32'(val)));
      vips_pkg::CfgRefY:  ry_ref  = longint'(signed'(32'(val)));
      vips_pkg::CfgRefZ:  rz_ref  = longint'(signed'(32'(val)));
      vips_pkg::CfgScale: scale   = val & 1023;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain_results();
    while (expected_points.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  // Offer one vertex; returns at the falling edge after it is accepted
  task automatic send_vertex(vertex_t v, bit gap_ok);
    if (gap_ok && !idle_off) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 0;
        @(negedge clk_i);
      end
    end
    in_valid_i    <= 1;
    pos_x_i       <= v.px;
    pos_y_i       <= v.py;
    pos_z_i       <= v.pz;
    norm_x_i      <= v.nx;
    norm_y_i      <= v.ny;
    norm_z_i      <= v.nz;
    last_vertex_i <= v.last;
    do @(posedge clk_i); while (in_stall_o);
    expected_points.push_back(shade_vertex(v));
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_q(int span);
    case ($urandom_range(9))
      0: return signed'($urandom);
      1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return signed'(32'($urandom_range(2 * span)) - 32'(span));
    endcase
  endfunction

  // Mostly well formed: unit-ish normal roughly along the eye vector
  function automatic vertex_t rnd_vertex();
    vertex_t v;
    if ($urandom_range(9) == 0) begin
      v = '{signed'($urandom), signed'($urandom), signed'($urandom),
            signed'($urandom), signed'($urandom), signed'($urandom), 1'b0};
    end else begin
      v.px = rnd_q(20 << 16);
      v.py = rnd_q(20 << 16);
      v.pz = rnd_q(30 << 16);
      v.nx = rnd_q(1 << 16);
      v.ny = rnd_q(1 << 16);
      v.nz = -rnd_q(1 << 16);
    end
    v.last = ($urandom_range(15) == 0);
    return v;
  endfunction

  // Directed table
  typedef struct {
    vertex_t v;
    bit      has_exp;
    point_t  e;
  } row_t;

  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;
  localparam logic signed [31:0] Q1   = 32'sh0001_0000;

  row_t table_rows[] = '{
    // all zero: alfa 0 below near, skipped
    '{'{0, 0, 0, 0, 0, 0, 1'b0}, 1, '{0, 0, 0, 0, 0, 0}},
    '{'{0, 0, 0, 0, 0, 0, 1'b1}, 1, '{0, 0, 0, 0, 0, 1}},
    // black point straight down the axis
    '{'{0, 0, 0, 0, 0, -(Q1 >>> 2), 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    // gray point
    '{'{0, 0, 0, 0, 0, -Q1, 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{Q1, Q1, -Q1, Q1, -Q1, -Q1, 1'b1}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{QMax, QMax, QMax, QMax, QMax, QMax, 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{QMin, QMin, QMin, QMin, QMin, QMin, 1'b1}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{QMax, QMin, QMax, QMin, QMax, QMin, 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{QMin, QMax, QMin, QMax, QMin, QMax, 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{-1, -1, -1, -1, -1, -1, 1'b1}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{5 * Q1, 0, 0, 4 * Q1, 0, 0, 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{0, -5 * Q1, 0, 0, -4 * Q1, 0, 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{0, 0, 29 * Q1, 0, 0, -Q1, 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{0, 0, -Q1, 0, 0, -32'sd1, 1'b0}, 0, '{0, 0, 0, 0, 0, 0}},
    '{'{3 * Q1, 4 * Q1, -10 * Q1, 0, 0, -Q1, 1'b1}, 0, '{0, 0, 0, 0, 0, 0}}
  };

  // Register settings for the random phases
  task automatic set_phase(int ph);
    case (ph)
      0: begin
        write_reg(vips_pkg::CfgEyeZ, 30 <<< 16);
        write_reg(vips_pkg::CfgNear, 5 <<< 16);
        write_reg(vips_pkg::CfgFar, 20 <<< 16);
        write_reg(vips_pkg::CfgRefX, 0);
        write_reg(vips_pkg::CfgRefY, -(5 <<< 16));
        write_reg(vips_pkg::CfgRefZ, -(30 <<< 16));
        write_reg(vips_pkg::CfgScale, 200);
      end
      1: begin
        write_reg(vips_pkg::CfgEyeZ, -2147483648);
        write_reg(vips_pkg::CfgNear, -2147483648);
        write_reg(vips_pkg::CfgFar, 2147483647);
        write_reg(vips_pkg::CfgRefX, 2147483647);
        write_reg(vips_pkg::CfgRefY, -2147483648);
        write_reg(vips_pkg::CfgRefZ, 2147483647);
        write_reg(vips_pkg::CfgScale, 1023);
      end
      2: begin
        write_reg(vips_pkg::CfgEyeZ, 2147483647);
        write_reg(vips_pkg::CfgNear, -2147483648);
        write_reg(vips_pkg::CfgFar, -2147483648);
        write_reg(vips_pkg::CfgRefX, -2147483648);
        write_reg(vips_pkg::CfgRefY, 2147483647);
        write_reg(vips_pkg::CfgRefZ, -2147483648);
        write_reg(vips_pkg::CfgScale, 1);
      end
      3: begin
        write_reg(vips_pkg::CfgScale, 0);
        write_reg(vips_pkg::CfgNear, 0);
        write_reg(vips_pkg::CfgFar, 2 <<< 16);
      end
      default: begin
        write_reg(vips_pkg::CfgEyeZ, signed'($urandom_range(60 << 16)) - (30 <<< 16));
        write_reg(vips_pkg::CfgNear, signed'($urandom_range(20 << 16)) - (10 <<< 16));
        write_reg(vips_pkg::CfgFar, signed'($urandom_range(40 << 16)));
        write_reg(vips_pkg::CfgRefX, signed'($urandom));
        write_reg(vips_pkg::CfgRefY, signed'($urandom_range(20 << 16)) - (10 <<< 16));
        write_reg(vips_pkg::CfgRefZ, signed'($urandom_range(60 << 16)) - (30 <<< 16));
        write_reg(vips_pkg::CfgScale, $urandom_range(1, 1023));
        write_reg(CfgUnused, $urandom);
      end
    endcase
  endtask

  initial begin
    point_t got;
    int n;
    rst_ni = 0;
    cfg_we_i = 0; cfg_addr_i = '0; cfg_wdata_i = '0;
    in_valid_i = 0;
    {pos_x_i, pos_y_i, pos_z_i, norm_x_i, norm_y_i, norm_z_i} = '0;
    last_vertex_i = 0;
    mismatches = 0;
    idle_off = 0; hold_off = 0;
    eye_z = 30 <<< 16; near_th = 5 <<< 16; far_th = 20 <<< 16;
    rx_ref = 0; ry_ref = -(5 <<< 16); rz_ref = -(30 <<< 16); scale = 200;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed rows under reset register values
    foreach (table_rows[i]) begin
      send_vertex(table_rows[i].v, 1);
      if (table_rows[i].has_exp) begin
        got = shade_vertex(table_rows[i].v);
        if (got != table_rows[i].e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: exp %h got %h", i, table_rows[i].e, got);
        end
      end
    end
    in_valid_i <= 0;
    drain_results();

    // Random phases
    for (int ph = 0; ph < 8; ph++) begin
      set_phase(ph);
      n = NumRandom / 8;
      for (int j = 0; j < n; j++) begin
        idle_off = (ph == 5);
        // Long receiver hold-off while the sender keeps offering
        if (ph == 2 && j == 10) begin
          hold_off = 1;
          fork
            begin
              repeat (Latency * 3) @(negedge clk_i);
              hold_off = 0;
            end
          join_none
        end
        send_vertex(rnd_vertex(), 1);
        // Pause until every result is back
        if (ph == 4 && j == n / 2) begin
          in_valid_i <= 0;
          while (expected_points.size() != 0) @(negedge clk_i);
        end
      end
      idle_off = 0;
      in_valid_i <= 0;
      drain_results();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
